>>> rtl/b64enc_pkg.sv
// b64enc_pkg: shared types, constants and the alphabet lookup of the base64 encoder.
// No dependencies; used by every module under rtl/ except b64enc_checker.
`default_nettype none
package b64enc_pkg;

    localparam int unsigned QDEPTH = 4;
    localparam int unsigned QPTR_W = $clog2(QDEPTH);
    localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

    localparam logic [7:0] PAD_CHAR    = 8'h3D;
    localparam logic [5:0] SEXTET_MASK = 6'h3F;

    // group of three byte slots, MSB byte first, with pad count and end-of-message flag
    typedef struct packed {
        logic [23:0] bits;
        logic [1:0]  npad;
        logic        last;
    } grp_t;

    typedef struct packed {
        logic full;
        logic empty;
    } qstat_t;

    function automatic logic [7:0] b64_char(input logic [5:0] v);
        logic [7:0] c;
        c = 8'h00;
        if (v < 6'd26) begin
            c = 8'h41 + {2'b00, v};
        end else if (v < 6'd52) begin
            c = 8'h61 + {2'b00, v - 6'd26};
        end else if (v < 6'd62) begin
            c = 8'h30 + {2'b00, v - 6'd52};
        end else if (v == 6'd62) begin
            c = 8'h2B;
        end else begin
            c = 8'h2F;
        end
        return c;
    endfunction

endpackage
`default_nettype wire

>>> rtl/b64enc_front.sv
// b64enc_front: accepts input bytes and gathers them into three-byte groups.
// Depends on b64enc_pkg; pushes finished groups into b64enc_queue.
`default_nettype none
module b64enc_front (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    input  wire logic [7:0]        s_tdata,
    input  wire logic              s_tlast,
    input  wire b64enc_pkg::qstat_t q_stat,
    output logic                   push,
    output b64enc_pkg::grp_t       push_grp
);

    logic [15:0] held_reg, held_next;
    logic [1:0]  pos_reg, pos_next;
    logic        acc;

    assign s_tready = !q_stat.full;
    assign acc      = s_tvalid && s_tready;

    always_comb begin
        held_next = held_reg;
        pos_next  = pos_reg;
        push      = 1'b0;
        push_grp  = '0;
        if (acc) begin
            case (pos_reg)
                2'd1: begin
                    if (!s_tlast) begin
                        held_next = {held_reg[7:0], s_tdata};
                        pos_next  = 2'd2;
                    end else begin
                        push          = 1'b1;
                        push_grp.bits = {held_reg[7:0], s_tdata, 8'h00};
                        push_grp.npad = 2'd1;
                        push_grp.last = 1'b1;
                        held_next     = '0;
                        pos_next      = 2'd0;
                    end
                end
                2'd2: begin
                    push          = 1'b1;
                    push_grp.bits = {held_reg, s_tdata};
                    push_grp.npad = 2'd0;
                    push_grp.last = s_tlast;
                    held_next     = '0;
                    pos_next      = 2'd0;
                end
                default: begin
                    // position 3 never arises; handled as start of group
                    if (!s_tlast) begin
                        held_next = {8'h00, s_tdata};
                        pos_next  = 2'd1;
                    end else begin
                        push          = 1'b1;
                        push_grp.bits = {s_tdata, 16'h0000};
                        push_grp.npad = 2'd2;
                        push_grp.last = 1'b1;
                        held_next     = '0;
                        pos_next      = 2'd0;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            held_reg <= '0;
            pos_reg  <= '0;
        end else begin
            held_reg <= held_next;
            pos_reg  <= pos_next;
        end
    end

endmodule
`default_nettype wire

>>> rtl/b64enc_queue.sv
// b64enc_queue: short FIFO of groups between the byte front and the character back.
// Depends on b64enc_pkg.
`default_nettype none
module b64enc_queue (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              push,
    input  wire b64enc_pkg::grp_t  push_grp,
    input  wire logic              pop,
    output b64enc_pkg::grp_t       head,
    output b64enc_pkg::qstat_t     q_stat
);

    b64enc_pkg::grp_t ent_reg [b64enc_pkg::QDEPTH];
    logic [b64enc_pkg::QPTR_W-1:0] wptr_reg, rptr_reg;
    logic [b64enc_pkg::QCNT_W-1:0] cnt_reg;
    logic do_push, do_pop;

    assign q_stat.full  = (cnt_reg == b64enc_pkg::QCNT_W'(b64enc_pkg::QDEPTH));
    assign q_stat.empty = (cnt_reg == '0);
    assign do_push      = push && !q_stat.full;
    assign do_pop       = pop && !q_stat.empty;
    assign head         = ent_reg[rptr_reg];

    always_ff @(posedge aclk) begin
        if (do_push) begin
            ent_reg[wptr_reg] <= push_grp;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            cnt_reg  <= '0;
        end else begin
            if (do_push) begin
                wptr_reg <= wptr_reg + 1'b1;
            end
            if (do_pop) begin
                rptr_reg <= rptr_reg + 1'b1;
            end
            case ({do_push, do_pop})
                2'b10:   cnt_reg <= cnt_reg + 1'b1;
                2'b01:   cnt_reg <= cnt_reg - 1'b1;
                default: cnt_reg <= cnt_reg;
            endcase
        end
    end

endmodule
`default_nettype wire

>>> rtl/b64enc_back.sv
// b64enc_back: turns queued groups into four characters, one word per cycle
// unless stalled. Depends on b64enc_pkg; drives the registered output channel.
`default_nettype none
module b64enc_back (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire b64enc_pkg::grp_t  head,
    input  wire b64enc_pkg::qstat_t q_stat,
    output logic                   pop,
    output logic                   m_tvalid,
    input  wire logic              m_tready,
    output logic [7:0]             m_tdata,
    output logic                   m_tlast
);

    logic [1:0] idx_reg, idx_next;
    logic       vld_reg, vld_next;
    logic [7:0] dat_reg, dat_next;
    logic       lst_reg, lst_next;
    logic       load;
    logic [5:0] sx;
    logic       is_pad;

    assign load = !vld_reg || m_tready;

    always_comb begin
        case (idx_reg)
            2'd0:    sx = head.bits[23:18];
            2'd1:    sx = head.bits[17:12];
            2'd2:    sx = head.bits[11:6];
            default: sx = head.bits[5:0] & b64enc_pkg::SEXTET_MASK;
        endcase
        // pads fill the tail: char index >= 4 - npad
        is_pad = ({1'b0, idx_reg} + {1'b0, head.npad}) >= 3'd4;
    end

    always_comb begin
        idx_next = idx_reg;
        vld_next = vld_reg;
        dat_next = dat_reg;
        lst_next = lst_reg;
        pop      = 1'b0;
        if (load) begin
            vld_next = !q_stat.empty;
            if (!q_stat.empty) begin
                dat_next = is_pad ? b64enc_pkg::PAD_CHAR : b64enc_pkg::b64_char(sx);
                lst_next = (idx_reg == 2'd3) && head.last;
                idx_next = idx_reg + 1'b1;
                pop      = (idx_reg == 2'd3);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg <= '0;
            vld_reg <= 1'b0;
        end else begin
            idx_reg <= idx_next;
            vld_reg <= vld_next;
        end
        dat_reg <= dat_next;
        lst_reg <= lst_next;
    end

    assign m_tvalid = vld_reg;
    assign m_tdata  = dat_reg;
    assign m_tlast  = lst_reg;

endmodule
`default_nettype wire

>>> rtl/base64_encoder.sv
// base64_encoder: top level of the streaming base64 encoder.
// Depends on b64enc_pkg, b64enc_front, b64enc_queue and b64enc_back.
//
//  channel | dir | tdata          | tlast
//  s_      | in  | data_byte[7:0] | final_byte
//  m_      | out | ascii_char[7:0]| final_char
//
// One byte is taken per cycle while the group queue has room.
// Each group leaves as four words from the output register, one per cycle unless
// the output stalls; for full groups the character back end limits the byte rate.
// The edge that takes a group's closing byte queues it for the output register.
// Reset clears group position, queue pointers and the output valid.
// A stalled output holds its word; the front keeps taking bytes until the queue fills.
`default_nettype none
module base64_encoder (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_tvalid,
    output logic            s_tready,
    input  wire logic [7:0] s_tdata,   // [7:0] data_byte
    input  wire logic       s_tlast,
    output logic            m_tvalid,
    input  wire logic       m_tready,
    output logic [7:0]      m_tdata,   // [7:0] ascii_char
    output logic            m_tlast
);

    b64enc_pkg::qstat_t q_stat;
    b64enc_pkg::grp_t   push_grp;
    b64enc_pkg::grp_t   head;
    logic               push;
    logic               pop;

    b64enc_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .q_stat   (q_stat),
        .push     (push),
        .push_grp (push_grp)
    );

    b64enc_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_grp (push_grp),
        .pop      (pop),
        .head     (head),
        .q_stat   (q_stat)
    );

    b64enc_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .head     (head),
        .q_stat   (q_stat),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule
`default_nettype wire

>>> rtl/b64enc_checker.sv
// b64enc_checker: port-level assertions for base64_encoder, attached by bind.
// Depends only on the top-level ports.
`default_nettype none
module b64enc_checker (
    input wire logic       aclk,
    input wire logic       aresetn,
    input wire logic       s_tvalid,
    input wire logic       s_tready,
    input wire logic [7:0] s_tdata,
    input wire logic       s_tlast,
    input wire logic       m_tvalid,
    input wire logic       m_tready,
    input wire logic [7:0] m_tdata,
    input wire logic       m_tlast
);

    a_hold_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("m_tvalid dropped while stalled");

    a_hold_data: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tlast))
        else $error("output word changed while stalled");

    a_charset: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> ((m_tdata >= 8'h41 && m_tdata <= 8'h5A) ||
                      (m_tdata >= 8'h61 && m_tdata <= 8'h7A) ||
                      (m_tdata >= 8'h30 && m_tdata <= 8'h39) ||
                      m_tdata == 8'h2B || m_tdata == 8'h2F || m_tdata == 8'h3D))
        else $error("output word not a base64 character");

    a_reset_idle: assert property (@(posedge aclk)
        $past(!aresetn) |-> !m_tvalid)
        else $error("output valid right after reset");

endmodule

bind base64_encoder b64enc_checker u_b64enc_checker (.*);
`default_nettype wire
